[rtl/bsmh_pkg.sv]
// ----------------------------------------------------------------------------
// Box stacking solver package
// Shared widths, defaults and orientation helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsmh_pkg;

    localparam int DIM_W         = 10;
    localparam int HEIGHT_W      = 16;
    localparam int ORIENT_W      = 3 * DIM_W;
    localparam int AREA_W        = 2 * DIM_W;
    localparam int MAX_BOXES_DEF = 16;

    typedef logic [DIM_W-1:0]    dim_t;
    typedef logic [ORIENT_W-1:0] orient_t;
    typedef logic [AREA_W-1:0]   area_t;

    // An orientation is packed as {long side, short side, height}.
    function automatic orient_t pack_orient(dim_t x, dim_t y, dim_t h);
        dim_t lo;
        dim_t sh;
        lo = (x > y) ? x : y;
        sh = (x > y) ? y : x;
        return {lo, sh, h};
    endfunction

    function automatic dim_t side_long(orient_t e);
        return e[3*DIM_W-1:2*DIM_W];
    endfunction

    function automatic dim_t side_short(orient_t e);
        return e[2*DIM_W-1:DIM_W];
    endfunction

    function automatic dim_t side_height(orient_t e);
        return e[DIM_W-1:0];
    endfunction

    function automatic area_t base_area(orient_t e);
        return AREA_W'(side_long(e)) * AREA_W'(side_short(e));
    endfunction

endpackage

`default_nettype wire

[rtl/bsmh_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/box_stacking_max_height_core.sv]
// ----------------------------------------------------------------------------
// Box stacking maximum height core
// Stores box orientations, ranks them by base area, runs the stacking DP
// over two RAMs and emits the tallest chain from top to bottom.
// ----------------------------------------------------------------------------
// A box that is not last makes 3 orientation writes, none if it is dropped.
// After the last box, a rank pass and then a DP pass run over the n
// orientations, both paced by the single read port of the orientation
// RAM; results then follow one per chain entry.
// The receiver cannot stall. Reset clears the control state and the count;
// RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module box_stacking_max_height_core #(
    parameter int MAX_BOXES = bsmh_pkg::MAX_BOXES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [bsmh_pkg::DIM_W-1:0]   dim_a,
    input  wire logic [bsmh_pkg::DIM_W-1:0]   dim_b,
    input  wire logic [bsmh_pkg::DIM_W-1:0]   dim_c,
    input  wire logic                         last_box,
    output logic                              result_valid,
    output logic [bsmh_pkg::HEIGHT_W-1:0]     max_height,
    output logic [bsmh_pkg::DIM_W-1:0]        base_long,
    output logic [bsmh_pkg::DIM_W-1:0]        base_short,
    output logic [bsmh_pkg::DIM_W-1:0]        box_height,
    output logic                              last_result
);

    localparam int ORIENT_MAX = 3 * MAX_BOXES;
    localparam int IW         = $clog2(ORIENT_MAX);
    localparam int CW         = $clog2(ORIENT_MAX + 1);
    localparam int OAW        = $clog2(2 * ORIENT_MAX);
    localparam int HW         = bsmh_pkg::HEIGHT_W;
    localparam int DPW        = HW + 1 + IW;

    localparam logic [OAW-1:0] S_BASE = OAW'(ORIENT_MAX);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_LOAD   = 4'd1;
    localparam logic [3:0] ST_R_OUT  = 4'd2;
    localparam logic [3:0] ST_R_WAIT = 4'd3;
    localparam logic [3:0] ST_R_IN   = 4'd4;
    localparam logic [3:0] ST_D_OUT  = 4'd5;
    localparam logic [3:0] ST_D_WAIT = 4'd6;
    localparam logic [3:0] ST_D_IN   = 4'd7;
    localparam logic [3:0] ST_E_RD   = 4'd8;
    localparam logic [3:0] ST_E_OUT  = 4'd9;

    logic [3:0]              state_reg, state_next;
    bsmh_pkg::dim_t          a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic                    last_reg, last_next;
    logic [1:0]              k_reg, k_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           i_reg, i_next;
    logic [CW-1:0]           j_reg, j_next;
    logic [CW-1:0]           jd_reg, jd_next;
    logic                    rv_reg, rv_next;
    bsmh_pkg::orient_t       key_reg, key_next;
    bsmh_pkg::area_t         karea_reg, karea_next;
    logic [CW-1:0]           rank_reg, rank_next;
    logic [HW-1:0]           best_reg, best_next;
    logic [IW-1:0]           pred_reg, pred_next;
    logic                    pvalid_reg, pvalid_next;
    logic [HW-1:0]           maxh_reg, maxh_next;
    logic [IW-1:0]           top_reg, top_next;
    logic [IW-1:0]           idx_reg, idx_next;
    logic                    rvalid_reg, rvalid_next;
    logic [HW-1:0]           omax_reg, omax_next;
    bsmh_pkg::orient_t       oent_reg, oent_next;
    logic                    olast_reg, olast_next;

    logic                    o_we;
    logic [OAW-1:0]          o_waddr;
    bsmh_pkg::orient_t       o_wdata;
    logic [OAW-1:0]          o_raddr;
    bsmh_pkg::orient_t       o_rdata;
    logic                    d_we;
    logic [IW-1:0]           d_waddr;
    logic [DPW-1:0]          d_wdata;
    logic [IW-1:0]           d_raddr;
    logic [DPW-1:0]          d_rdata;

    bsmh_ram #(
        .WIDTH (bsmh_pkg::ORIENT_W),
        .DEPTH (2 * ORIENT_MAX)
    ) u_orient_ram (
        .clk   (clk),
        .we    (o_we),
        .waddr (o_waddr),
        .wdata (o_wdata),
        .raddr (o_raddr),
        .rdata (o_rdata)
    );

    bsmh_ram #(
        .WIDTH (DPW),
        .DEPTH (ORIENT_MAX)
    ) u_dp_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    always_comb
    begin
        bsmh_pkg::area_t   aj;
        logic [CW-1:0]     rank_n;
        logic [HW-1:0]     cand;
        logic [HW-1:0]     nb;
        logic              npv;
        logic [IW-1:0]     npd;
        logic              commit;
        logic [HW-1:0]     c_best;
        logic              c_pv;
        logic [IW-1:0]     c_pd;
        logic [IW-1:0]     new_top;

        state_next  = state_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        last_next   = last_reg;
        k_next      = k_reg;
        count_next  = count_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        jd_next     = jd_reg;
        rv_next     = rv_reg;
        key_next    = key_reg;
        karea_next  = karea_reg;
        rank_next   = rank_reg;
        best_next   = best_reg;
        pred_next   = pred_reg;
        pvalid_next = pvalid_reg;
        maxh_next   = maxh_reg;
        top_next    = top_reg;
        idx_next    = idx_reg;
        rvalid_next = 1'b0;
        omax_next   = omax_reg;
        oent_next   = oent_reg;
        olast_next  = olast_reg;

        o_we    = 1'b0;
        o_waddr = '0;
        o_wdata = key_reg;
        o_raddr = '0;
        d_we    = 1'b0;
        d_waddr = '0;
        d_wdata = '0;
        d_raddr = '0;

        aj      = bsmh_pkg::base_area(o_rdata);
        rank_n  = rank_reg;
        cand    = d_rdata[DPW-1 -: HW] + HW'(bsmh_pkg::side_height(key_reg));
        nb      = best_reg;
        npv     = pvalid_reg;
        npd     = pred_reg;
        commit  = 1'b0;
        c_best  = best_reg;
        c_pv    = pvalid_reg;
        c_pd    = pred_reg;
        new_top = top_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    a_next    = dim_a;
                    b_next    = dim_b;
                    c_next    = dim_c;
                    last_next = last_box;
                    k_next    = '0;
                    i_next    = '0;
                    if ((CW+1)'(count_reg) + (CW+1)'(3) <= (CW+1)'(ORIENT_MAX))
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (last_box)
                    begin
                        state_next = ST_R_OUT;
                    end
                end
            end
            ST_LOAD:
            begin
                o_we    = 1'b1;
                o_waddr = OAW'(count_reg);
                case (k_reg)
                    2'd0:    o_wdata = bsmh_pkg::pack_orient(a_reg, b_reg, c_reg);
                    2'd1:    o_wdata = bsmh_pkg::pack_orient(b_reg, c_reg, a_reg);
                    default: o_wdata = bsmh_pkg::pack_orient(c_reg, a_reg, b_reg);
                endcase
                count_next = count_reg + CW'(1);
                k_next     = k_reg + 2'd1;
                if (k_reg == 2'd2)
                begin
                    state_next = last_reg ? ST_R_OUT : ST_IDLE;
                end
            end
            ST_R_OUT:
            begin
                o_raddr    = OAW'(i_reg);
                state_next = ST_R_WAIT;
            end
            ST_R_WAIT:
            begin
                key_next   = o_rdata;
                karea_next = aj;
                j_next     = '0;
                rv_next    = 1'b0;
                rank_next  = '0;
                state_next = ST_R_IN;
            end
            ST_R_IN:
            begin
                o_raddr = OAW'(j_reg);
                j_next  = j_reg + CW'(1);
                rv_next = (j_reg < count_reg);
                jd_next = j_reg;
                if (rv_reg)
                begin
                    if ((aj > karea_reg) || ((aj == karea_reg) && (jd_reg < i_reg)))
                    begin
                        rank_n = rank_reg + CW'(1);
                    end
                    rank_next = rank_n;
                    if (jd_reg + CW'(1) == count_reg)
                    begin
                        o_we    = 1'b1;
                        o_waddr = S_BASE + OAW'(rank_n[IW-1:0]);
                        o_wdata = key_reg;
                        i_next  = i_reg + CW'(1);
                        rv_next = 1'b0;
                        if (i_reg + CW'(1) == count_reg)
                        begin
                            i_next     = '0;
                            state_next = ST_D_OUT;
                        end
                        else
                        begin
                            state_next = ST_R_OUT;
                        end
                    end
                end
            end
            ST_D_OUT:
            begin
                o_raddr    = S_BASE + OAW'(i_reg[IW-1:0]);
                state_next = ST_D_WAIT;
            end
            ST_D_WAIT:
            begin
                key_next    = o_rdata;
                best_next   = HW'(bsmh_pkg::side_height(o_rdata));
                pvalid_next = 1'b0;
                pred_next   = '0;
                j_next      = '0;
                rv_next     = 1'b0;
                if (i_reg == '0)
                begin
                    commit = 1'b1;
                    c_best = HW'(bsmh_pkg::side_height(o_rdata));
                    c_pv   = 1'b0;
                    c_pd   = '0;
                end
                else
                begin
                    state_next = ST_D_IN;
                end
            end
            ST_D_IN:
            begin
                o_raddr = S_BASE + OAW'(j_reg[IW-1:0]);
                d_raddr = j_reg[IW-1:0];
                j_next  = j_reg + CW'(1);
                rv_next = (j_reg < i_reg);
                jd_next = j_reg;
                if (rv_reg)
                begin
                    if ((bsmh_pkg::side_long(key_reg) < bsmh_pkg::side_long(o_rdata))
                        && (bsmh_pkg::side_short(key_reg) < bsmh_pkg::side_short(o_rdata))
                        && (best_reg < cand))
                    begin
                        nb  = cand;
                        npv = 1'b1;
                        npd = jd_reg[IW-1:0];
                    end
                    best_next   = nb;
                    pvalid_next = npv;
                    pred_next   = npd;
                    if (jd_reg + CW'(1) == i_reg)
                    begin
                        commit = 1'b1;
                        c_best = nb;
                        c_pv   = npv;
                        c_pd   = npd;
                    end
                end
            end
            ST_E_RD:
            begin
                o_raddr    = S_BASE + OAW'(idx_reg);
                d_raddr    = idx_reg;
                state_next = ST_E_OUT;
            end
            ST_E_OUT:
            begin
                rvalid_next = 1'b1;
                omax_next   = maxh_reg;
                oent_next   = o_rdata;
                olast_next  = !d_rdata[IW];
                if (d_rdata[IW])
                begin
                    idx_next   = d_rdata[IW-1:0];
                    state_next = ST_E_RD;
                end
                else
                begin
                    count_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (commit)
        begin
            d_we    = 1'b1;
            d_waddr = i_reg[IW-1:0];
            d_wdata = {c_best, c_pv, c_pd};
            if ((i_reg == '0) || (c_best > maxh_reg))
            begin
                maxh_next = c_best;
                new_top   = i_reg[IW-1:0];
            end
            top_next = new_top;
            i_next   = i_reg + CW'(1);
            rv_next  = 1'b0;
            if (i_reg + CW'(1) == count_reg)
            begin
                idx_next   = new_top;
                state_next = ST_E_RD;
            end
            else
            begin
                state_next = ST_D_OUT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        last_reg   <= last_next;
        k_reg      <= k_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        jd_reg     <= jd_next;
        rv_reg     <= rv_next;
        key_reg    <= key_next;
        karea_reg  <= karea_next;
        rank_reg   <= rank_next;
        best_reg   <= best_next;
        pred_reg   <= pred_next;
        pvalid_reg <= pvalid_next;
        maxh_reg   <= maxh_next;
        top_reg    <= top_next;
        idx_reg    <= idx_next;
        omax_reg   <= omax_next;
        oent_reg   <= oent_next;
        olast_reg  <= olast_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = rvalid_reg;
    assign max_height   = omax_reg;
    assign base_long    = bsmh_pkg::side_long(oent_reg);
    assign base_short   = bsmh_pkg::side_short(oent_reg);
    assign box_height   = bsmh_pkg::side_height(oent_reg);
    assign last_result  = olast_reg;

endmodule

`default_nettype wire

[rtl/bsmh_checker.sv]
// ----------------------------------------------------------------------------
// Box stacking core checker
// Port-level properties of the result stream, bound to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsmh_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          last_box,
    input wire logic                          result_valid,
    input wire logic [bsmh_pkg::HEIGHT_W-1:0] max_height,
    input wire logic                          last_result
);

    // A chain continues after a result that is not the bottom one.
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_result |-> busy)
        else $error("core idle in the middle of a chain");

    // The bottom result ends the transaction.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_result |-> !busy)
        else $error("core still busy after the bottom result");

    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("results on consecutive cycles");

    a_same_max: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && $past(result_valid, 2) && !$past(last_result, 2)
        |-> max_height == $past(max_height, 2))
        else $error("maximum height changed within a chain");

    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !last_box |=> !result_valid)
        else $error("result after a box that is not last");

endmodule

bind box_stacking_max_height_core bsmh_checker u_bsmh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .last_box     (last_box),
    .result_valid (result_valid),
    .max_height   (max_height),
    .last_result  (last_result)
);

`default_nettype wire
